/* design/pwlti_pkg.sv */
// ----------------------------------------------------------------------------
// pwlti_pkg
// Types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package pwlti_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = 9;
  localparam int VAL_BITS    = 32;
  localparam int FRAC_BITS   = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic [7:0]                  point_index;
    logic signed [VAL_BITS-1:0]  point_x;
    logic signed [VAL_BITS-1:0]  point_y;
    logic signed [VAL_BITS-1:0]  query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0]  interp_y;
    logic                        status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SRCH_CHK,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

/* design/piecewise_linear_table_interp.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Breakpoint table with linear interpolation between neighboring points.
// ----------------------------------------------------------------------------
// One item is taken while busy is low. A load item writes one breakpoint into
// the x and y memories, gives no result and leaves busy low. A query item
// gives one result, shown for exactly one cycle under out_valid; the receiver
// cannot stall it. A query reads the first and last points, then scans the x
// memory downward from the second-to-last point, one entry a cycle, to the
// last point at or below the query, reads the segment end and runs a
// restoring divider for the weight and one multiply. A query that clamps to
// the first or last point, or finds the table empty, skips the rest and ends.
module piecewise_linear_table_interp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  pwlti_pkg::in_item_t       in_item,
  output logic                      out_valid,
  output pwlti_pkg::out_item_t      out_item,
  input  logic                      cfg_we,
  input  logic [pwlti_pkg::CNT_BITS-1:0] cfg_wdata
);
  import pwlti_pkg::*;

  logic signed [VAL_BITS-1:0] mem_x [TABLE_DEPTH];
  logic signed [VAL_BITS-1:0] mem_y [TABLE_DEPTH];
  logic [IDX_BITS-1:0]        rd_addr;
  logic signed [VAL_BITS-1:0] rd_x_r, rd_y_r;

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] piu_r;
  logic [CNT_BITS-1:0] n_eff;
  logic signed [VAL_BITS-1:0] q_r;
  logic [IDX_BITS-1:0] lo_r, lo_nxt;
  logic signed [VAL_BITS-1:0] x1_r, y1_r;
  logic signed [VAL_BITS:0]   den_r;
  logic [VAL_BITS:0]          rem_r;
  logic [FRAC_BITS:0]         t_r;
  logic [4:0]                 cnt_r;
  logic signed [VAL_BITS+FRAC_BITS+2:0] prod_r;
  logic signed [VAL_BITS+1:0] res_r;
  logic                       empty_r;
  logic                       load_go, query_go;
  logic [VAL_BITS:0]          rem_sh;

  assign n_eff    = (piu_r > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : piu_r;
  assign load_go  = start && !busy && in_item.req_type == REQ_LOAD;
  assign query_go = start && !busy && in_item.req_type == REQ_QUERY;
  assign rem_sh   = {rem_r[VAL_BITS-1:0], 1'b0};

  // memory read address per state
  always_comb begin
    unique case (state_r)
      ST_IDLE:      rd_addr = '0;
      ST_RD_FIRST:  rd_addr = '0;
      ST_CHK_FIRST: rd_addr = IDX_BITS'(n_eff - 1'b1);
      ST_CHK_LAST:  rd_addr = IDX_BITS'(n_eff - 2'd2);
      ST_SRCH_CHK:  rd_addr = lo_r - 1'b1;
      ST_SEG_RD:    rd_addr = IDX_BITS'(lo_r + 1'b1);
      default:      rd_addr = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      mem_x[in_item.point_index] <= in_item.point_x;
      mem_y[in_item.point_index] <= in_item.point_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= '0;
    end else if (cfg_we) begin
      piu_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (query_go) state_nxt = ST_RD_FIRST;
      ST_RD_FIRST:  state_nxt = (n_eff == '0) ? ST_DONE : ST_CHK_FIRST;
      ST_CHK_FIRST: state_nxt = (q_r <= rd_x_r) ? ST_DONE : ST_CHK_LAST;
      ST_CHK_LAST:  state_nxt = (q_r >= rd_x_r) ? ST_DONE : ST_SRCH_CHK;
      ST_SRCH_CHK:  state_nxt = (rd_x_r <= q_r) ? ST_SEG_RD : ST_SRCH_CHK;
      ST_SEG_RD:    state_nxt = ST_SEG_CHK;
      ST_SEG_CHK:   state_nxt = (rd_x_r == x1_r) ? ST_DONE : ST_DIV;
      ST_DIV:       if (cnt_r == 5'd0) state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // downward scan: lo is the entry whose x is on the read port; the first
  // point is known to lie below q, so the scan always stops
  always_comb begin
    lo_nxt = lo_r;
    if (state_r == ST_CHK_LAST) begin
      lo_nxt = IDX_BITS'(n_eff - 2'd2);
    end else if (state_r == ST_SRCH_CHK && rd_x_r > q_r) begin
      lo_nxt = lo_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    unique case (state_r)
      ST_IDLE: begin
        q_r     <= in_item.query_x;
        empty_r <= 1'b0;
      end
      ST_RD_FIRST: begin
        empty_r <= (n_eff == '0);
        res_r   <= '0;
      end
      ST_CHK_FIRST: res_r <= (VAL_BITS+2)'(rd_y_r);
      ST_CHK_LAST:  res_r <= (VAL_BITS+2)'(rd_y_r);
      ST_SRCH_CHK: begin
        x1_r <= rd_x_r;
        y1_r <= rd_y_r;
      end
      ST_SEG_CHK: begin
        res_r <= (VAL_BITS+2)'(y1_r);
        den_r <= (VAL_BITS+1)'(rd_x_r) - (VAL_BITS+1)'(x1_r);
        rem_r <= (VAL_BITS+1)'(q_r) - (VAL_BITS+1)'(x1_r);
        prod_r <= (VAL_BITS+FRAC_BITS+3)'((VAL_BITS+1)'(rd_y_r) - (VAL_BITS+1)'(y1_r));
        t_r   <= '0;
        cnt_r <= 5'd16;
      end
      ST_DIV: begin
        // x1 <= q < x2 so 0 <= num < den; restoring division, one bit a step
        if (cnt_r != 5'd0) begin
          cnt_r <= cnt_r - 1'b1;
          if (rem_sh >= $unsigned(den_r)) begin
            rem_r <= rem_sh - $unsigned(den_r);
            t_r   <= {t_r[FRAC_BITS-1:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            t_r   <= {t_r[FRAC_BITS-1:0], 1'b0};
          end
        end
      end
      ST_MUL: prod_r <= $signed({1'b0, t_r}) * $signed(prod_r[VAL_BITS:0]);
      ST_SUM: res_r <= (VAL_BITS+2)'(y1_r) +
                       (VAL_BITS+2)'(prod_r >>> FRAC_BITS);
      default: ;
    endcase
  end

  logic signed [VAL_BITS-1:0] sat_y;
  localparam logic signed [VAL_BITS+1:0] VMAX = (VAL_BITS+2)'({1'b0, {(VAL_BITS-1){1'b1}}});
  localparam logic signed [VAL_BITS+1:0] VMIN = -VMAX - 1;
  always_comb begin
    priority if (res_r > VMAX) sat_y = VMAX[VAL_BITS-1:0];
    else if (res_r < VMIN)     sat_y = VMIN[VAL_BITS-1:0];
    else                       sat_y = res_r[VAL_BITS-1:0];
  end

  // outputs
  always_comb begin
    busy               = (state_r != ST_IDLE);
    out_valid          = (state_r == ST_DONE);
    out_item.interp_y  = sat_y;
    out_item.status    = empty_r ? STATUS_EMPTY : STATUS_OK;
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    query_go |=> busy) else $error("query not started");
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_go |=> !busy) else $error("load made block busy");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STATUS_EMPTY |-> out_item.interp_y == '0)
    else $error("empty result not zero");

endmodule
